>>> sv/nirt_pkg.sv
// ----------------------------------------------------------------------------
// NEC infrared transmitter package
// Shared constants, register indexes, phase codes and the structures that
// pass configuration and results between the modules of the transmitter.
// ----------------------------------------------------------------------------
package nirt_pkg;

   // Code length: default, and the narrowest and widest the design supports.
   localparam int CODE_BITS_DEFAULT = 32;
   localparam int CODE_BITS_MIN     = 8;
   localparam int CODE_BITS_MAX     = 64;

   // Field widths of the channels and the configuration port.
   localparam int FRAME_CODE_W = 32;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;

   // Timing field widths.
   localparam int HALF_W   = 8;
   localparam int LMARK_W  = 10;
   localparam int BMARK_W  = 8;
   localparam int SPACE_W  = 16;
   localparam int TICK_W   = 16;
   localparam int CYCLE_W  = 10;

   // Register reset values (one microsecond ticks, 26 us carrier period).
   localparam logic [HALF_W-1:0]  CARRIER_HALF_RESET = 8'd13;
   localparam logic [LMARK_W-1:0] LEADER_MARK_RESET  = 10'd346;
   localparam logic [SPACE_W-1:0] LEADER_SPACE_RESET = 16'd4500;
   localparam logic [BMARK_W-1:0] BIT_MARK_RESET     = 8'd21;
   localparam logic [SPACE_W-1:0] ZERO_SPACE_RESET   = 16'd562;
   localparam logic [SPACE_W-1:0] ONE_SPACE_RESET    = 16'd1686;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CARRIER_HALF = 3'd0,
      CSR_LEADER_MARK  = 3'd1,
      CSR_LEADER_SPACE = 3'd2,
      CSR_BIT_MARK     = 3'd3,
      CSR_ZERO_SPACE   = 3'd4,
      CSR_ONE_SPACE    = 3'd5
   } csr_index_type;

   // Frame phases.
   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_LEAD_MARK  = 3'd1,
      PH_LEAD_SPACE = 3'd2,
      PH_BIT_MARK   = 3'd3,
      PH_BIT_SPACE  = 3'd4,
      PH_STOP_MARK  = 3'd5
   } phase_type;

   // Request command codes.
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   typedef struct packed {
      logic [HALF_W-1:0]  carrier_half_ticks;
      logic [LMARK_W-1:0] leader_mark_cycles;
      logic [SPACE_W-1:0] leader_space_ticks;
      logic [BMARK_W-1:0] bit_mark_cycles;
      logic [SPACE_W-1:0] zero_space_ticks;
      logic [SPACE_W-1:0] one_space_ticks;
   } cfg_type;

   typedef struct packed {
      logic ir_level;
      logic busy_res;
      logic start_accepted;
      logic frame_done;
   } result_type;

endpackage

>>> sv/nirt_if.sv
// ----------------------------------------------------------------------------
// NEC infrared transmitter channel interfaces
// Valid/ready channels for requests (tick or start) and for results.
// ----------------------------------------------------------------------------
interface nirt_req_if;
   logic                              valid;
   logic                              ready;
   logic                              command;
   logic [nirt_pkg::FRAME_CODE_W-1:0] frame_code;

   modport source (output valid, output command, output frame_code, input ready);
   modport sink   (input valid, input command, input frame_code, output ready);
endinterface

interface nirt_rsp_if;
   logic valid;
   logic ready;
   logic ir_level;
   logic busy_res;
   logic start_accepted;
   logic frame_done;

   modport source (output valid, output ir_level, output busy_res,
                   output start_accepted, output frame_done, input ready);
   modport sink   (input valid, input ir_level, input busy_res,
                   input start_accepted, input frame_done, output ready);
endinterface

>>> sv/nec_ir_transmitter_unit.sv
// ----------------------------------------------------------------------------
// NEC infrared transmitter unit
// Top level: request register, frame engine, result register and the
// timing register file.
// ----------------------------------------------------------------------------
// Usage. Each request on req_chan is either a time tick (command 0, one
// microsecond with the reset register values) or a start (command 1) that
// carries the 32-bit frame code. Every request yields exactly one result on
// rsp_chan: the LED drive level for that tick, whether a frame is in
// progress, whether a start was taken and whether the frame ended.
// A request is accepted into the request register; its result is written
// into the result register when the engine steps on it. One request is
// accepted every cycle while the receiver takes results, so a tick stream
// at full clock rate is carried without gaps. The rate is set by the frame
// engine, whose state updates once per request between the two registers.
// When the receiver holds rsp_chan.ready low, the waiting result stays in
// its register, one further request is held in the request register, and
// req_chan.ready then falls until the result is taken; nothing is lost.
// The timing registers are written on the csr_ port, one per cycle, and
// should be changed only while the unit is idle.
// A synchronous reset empties both registers, returns the engine to idle
// with the LED off and reloads the default NEC timing.
module nec_ir_transmitter_unit #(
   parameter int CODE_BITS = nirt_pkg::CODE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   nirt_req_if.sink                         req_chan,
   nirt_rsp_if.source                       rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [nirt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nirt_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   // The code length must stay within what the shift register supports.
   if (CODE_BITS < nirt_pkg::CODE_BITS_MIN || CODE_BITS > nirt_pkg::CODE_BITS_MAX) begin : g_bad
      $error("CODE_BITS out of range");
   end

   nirt_pkg::cfg_type                 cfg;
   nirt_pkg::result_type              result;

   // Request register.
   logic                              req_valid_ff;
   logic                              req_command_ff;
   logic [nirt_pkg::FRAME_CODE_W-1:0] req_code_ff;

   // Result register.
   logic                              rsp_valid_ff;
   nirt_pkg::result_type              rsp_data_ff;

   logic                              advance;
   logic                              req_take;

   // The engine steps whenever a request is held and the result register is
   // free or is being emptied in this cycle.
   assign advance  = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         req_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_command_ff <= req_chan.command;
         req_code_ff    <= req_chan.frame_code;
      end
   end

   nirt_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .write_enable (csr_write_enable),
      .index        (csr_index),
      .write_data   (csr_write_data),
      .cfg          (cfg)
   );

   nirt_engine #(
      .CODE_BITS (CODE_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .command    (req_command_ff),
      .frame_code (req_code_ff),
      .cfg        (cfg),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.ir_level       = rsp_data_ff.ir_level;
   assign rsp_chan.busy_res       = rsp_data_ff.busy_res;
   assign rsp_chan.start_accepted = rsp_data_ff.start_accepted;
   assign rsp_chan.frame_done     = rsp_data_ff.frame_done;

endmodule

>>> sv/nirt_csr.sv
// ----------------------------------------------------------------------------
// NEC infrared transmitter register file
// Holds the six timing registers written through the plain write port.
// ----------------------------------------------------------------------------
module nirt_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             write_enable,
   input  logic [nirt_pkg::CSR_INDEX_W-1:0] index,
   input  logic [nirt_pkg::CSR_DATA_W-1:0]  write_data,
   output nirt_pkg::cfg_type                cfg
);

   nirt_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.carrier_half_ticks <= nirt_pkg::CARRIER_HALF_RESET;
         cfg_ff.leader_mark_cycles <= nirt_pkg::LEADER_MARK_RESET;
         cfg_ff.leader_space_ticks <= nirt_pkg::LEADER_SPACE_RESET;
         cfg_ff.bit_mark_cycles    <= nirt_pkg::BIT_MARK_RESET;
         cfg_ff.zero_space_ticks   <= nirt_pkg::ZERO_SPACE_RESET;
         cfg_ff.one_space_ticks    <= nirt_pkg::ONE_SPACE_RESET;
      end else if (write_enable) begin
         // Indexes beyond the register list are dropped.
         case (index)
            nirt_pkg::CSR_CARRIER_HALF: begin
               cfg_ff.carrier_half_ticks <= write_data[nirt_pkg::HALF_W-1:0];
            end
            nirt_pkg::CSR_LEADER_MARK: begin
               cfg_ff.leader_mark_cycles <= write_data[nirt_pkg::LMARK_W-1:0];
            end
            nirt_pkg::CSR_LEADER_SPACE: begin
               cfg_ff.leader_space_ticks <= write_data[nirt_pkg::SPACE_W-1:0];
            end
            nirt_pkg::CSR_BIT_MARK: begin
               cfg_ff.bit_mark_cycles <= write_data[nirt_pkg::BMARK_W-1:0];
            end
            nirt_pkg::CSR_ZERO_SPACE: begin
               cfg_ff.zero_space_ticks <= write_data[nirt_pkg::SPACE_W-1:0];
            end
            nirt_pkg::CSR_ONE_SPACE: begin
               cfg_ff.one_space_ticks <= write_data[nirt_pkg::SPACE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/nirt_engine.sv
// ----------------------------------------------------------------------------
// NEC infrared transmitter frame engine
// Frame state machine: per step, advances one tick or, when idle, takes a
// start, and produces the result for that request.
// ----------------------------------------------------------------------------
module nirt_engine #(
   parameter int CODE_BITS = nirt_pkg::CODE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic                              command,
   input  logic [nirt_pkg::FRAME_CODE_W-1:0] frame_code,
   input  nirt_pkg::cfg_type                 cfg,
   output nirt_pkg::result_type              result
);

   localparam int BL_W = $clog2(CODE_BITS + 1);

   nirt_pkg::phase_type                phase_ff, phase_in;
   logic [CODE_BITS-1:0]               code_ff, code_in;
   logic [BL_W-1:0]                    bits_ff, bits_in;
   logic [nirt_pkg::TICK_W-1:0]        tick_ff, tick_in;
   logic [nirt_pkg::CYCLE_W-1:0]       cycle_ff, cycle_in;
   logic                               carrier_ff, carrier_in;

   logic [nirt_pkg::CODE_BITS_MAX-1:0] code_ext;
   logic                               is_mark;
   logic [nirt_pkg::LMARK_W-1:0]       mark_cycles;
   logic [nirt_pkg::SPACE_W-1:0]       space_len;
   logic [nirt_pkg::TICK_W:0]          tick_inc;
   logic [nirt_pkg::CYCLE_W:0]         cycle_inc;
   logic                               half_end, cycles_end, space_end;
   logic [BL_W-1:0]                    bits_dec;

   assign code_ext = {{(nirt_pkg::CODE_BITS_MAX - nirt_pkg::FRAME_CODE_W){1'b0}}, frame_code};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= nirt_pkg::PH_IDLE;
         code_ff    <= '0;
         bits_ff    <= '0;
         tick_ff    <= '0;
         cycle_ff   <= '0;
         carrier_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         code_ff    <= code_in;
         bits_ff    <= bits_in;
         tick_ff    <= tick_in;
         cycle_ff   <= cycle_in;
         carrier_ff <= carrier_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      code_in    = code_ff;
      bits_in    = bits_ff;
      tick_in    = tick_ff;
      cycle_in   = cycle_ff;
      carrier_in = carrier_ff;

      is_mark = (phase_ff == nirt_pkg::PH_LEAD_MARK) || (phase_ff == nirt_pkg::PH_BIT_MARK) ||
                (phase_ff == nirt_pkg::PH_STOP_MARK);
      mark_cycles = (phase_ff == nirt_pkg::PH_LEAD_MARK) ? cfg.leader_mark_cycles :
                    {{(nirt_pkg::LMARK_W - nirt_pkg::BMARK_W){1'b0}}, cfg.bit_mark_cycles};
      if (phase_ff == nirt_pkg::PH_LEAD_SPACE) begin
         space_len = cfg.leader_space_ticks;
      end else if (code_ff[CODE_BITS-1]) begin
         space_len = cfg.one_space_ticks;
      end else begin
         space_len = cfg.zero_space_ticks;
      end

      // A zero length register compares as already reached, so it acts as one.
      tick_inc   = {1'b0, tick_ff} + 1'b1;
      cycle_inc  = {1'b0, cycle_ff} + 1'b1;
      half_end   = tick_inc >= {{(nirt_pkg::TICK_W + 1 - nirt_pkg::HALF_W){1'b0}},
                               cfg.carrier_half_ticks};
      cycles_end = cycle_inc >= {1'b0, mark_cycles};
      space_end  = tick_inc >= {1'b0, space_len};
      bits_dec   = (bits_ff != '0) ? bits_ff - 1'b1 : bits_ff;

      result.ir_level       = is_mark & carrier_ff;
      result.start_accepted = 1'b0;
      result.frame_done     = 1'b0;

      if (step) begin
         if (command == nirt_pkg::CMD_START) begin
            if (phase_ff == nirt_pkg::PH_IDLE) begin
               code_in    = code_ext[CODE_BITS-1:0];
               bits_in    = BL_W'(CODE_BITS);
               phase_in   = nirt_pkg::PH_LEAD_MARK;
               tick_in    = '0;
               cycle_in   = '0;
               carrier_in = 1'b1;
               result.start_accepted = 1'b1;
            end
         end else begin
            case (phase_ff)
               nirt_pkg::PH_IDLE: begin
               end
               nirt_pkg::PH_LEAD_MARK, nirt_pkg::PH_BIT_MARK, nirt_pkg::PH_STOP_MARK: begin
                  tick_in = tick_inc[nirt_pkg::TICK_W-1:0];
                  if (half_end) begin
                     tick_in = '0;
                     if (carrier_ff) begin
                        carrier_in = 1'b0;
                     end else begin
                        carrier_in = 1'b1;
                        cycle_in   = cycle_inc[nirt_pkg::CYCLE_W-1:0];
                        if (cycles_end) begin
                           // End of the mark: the carrier stays off.
                           carrier_in = 1'b0;
                           if (phase_ff == nirt_pkg::PH_LEAD_MARK) begin
                              phase_in = nirt_pkg::PH_LEAD_SPACE;
                           end else if (phase_ff == nirt_pkg::PH_BIT_MARK) begin
                              phase_in = nirt_pkg::PH_BIT_SPACE;
                           end else begin
                              phase_in          = nirt_pkg::PH_IDLE;
                              cycle_in          = '0;
                              result.frame_done = 1'b1;
                           end
                        end
                     end
                  end
               end
               nirt_pkg::PH_LEAD_SPACE: begin
                  tick_in = tick_inc[nirt_pkg::TICK_W-1:0];
                  if (space_end) begin
                     phase_in   = (bits_ff != '0) ? nirt_pkg::PH_BIT_MARK :
                                                    nirt_pkg::PH_STOP_MARK;
                     tick_in    = '0;
                     cycle_in   = '0;
                     carrier_in = 1'b1;
                  end
               end
               nirt_pkg::PH_BIT_SPACE: begin
                  tick_in = tick_inc[nirt_pkg::TICK_W-1:0];
                  if (space_end) begin
                     code_in    = {code_ff[CODE_BITS-2:0], 1'b0};
                     bits_in    = bits_dec;
                     phase_in   = (bits_dec != '0) ? nirt_pkg::PH_BIT_MARK :
                                                     nirt_pkg::PH_STOP_MARK;
                     tick_in    = '0;
                     cycle_in   = '0;
                     carrier_in = 1'b1;
                  end
               end
               default: begin
                  phase_in = nirt_pkg::PH_IDLE;
               end
            endcase
         end
      end

      result.busy_res = (phase_in != nirt_pkg::PH_IDLE);
   end

   // The carrier may only be on during a mark.
   assert property (@(posedge clock) disable iff (reset)
      carrier_ff |-> ((phase_ff == nirt_pkg::PH_LEAD_MARK) ||
                      (phase_ff == nirt_pkg::PH_BIT_MARK) ||
                      (phase_ff == nirt_pkg::PH_STOP_MARK)))
      else $error("carrier on outside a mark");

   // A taken start always opens the leader mark with the carrier on.
   assert property (@(posedge clock) disable iff (reset)
      (step && result.start_accepted) |=>
         (phase_ff == nirt_pkg::PH_LEAD_MARK) && carrier_ff && (bits_ff == BL_W'(CODE_BITS)))
      else $error("start did not open the leader mark");

   // The end of the stop mark returns the engine to idle.
   assert property (@(posedge clock) disable iff (reset)
      (step && result.frame_done) |=> (phase_ff == nirt_pkg::PH_IDLE) && !carrier_ff)
      else $error("frame end did not return to idle");

   // The bit counter never exceeds the code length.
   assert property (@(posedge clock) disable iff (reset)
      bits_ff <= BL_W'(CODE_BITS))
      else $error("bit counter out of range");

   // Without a step the frame state holds.
   assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(tick_ff) && $stable(bits_ff))
      else $error("state moved without a step");

endmodule
